[rtl/core/srr_pkg.sv]
package srr_pkg;

	localparam logic [2:0] CMD_SEND    = 3'd0;
	localparam logic [2:0] CMD_RECV    = 3'd1;
	localparam logic [2:0] CMD_REPLY   = 3'd2;
	localparam logic [2:0] CMD_DESTROY = 3'd3;
	localparam logic [2:0] CMD_CREATE  = 3'd4;

	localparam logic [1:0] IPC_RUN    = 2'd0;
	localparam logic [1:0] IPC_BSEND  = 2'd1;
	localparam logic [1:0] IPC_BRECV  = 2'd2;
	localparam logic [1:0] IPC_BREPLY = 2'd3;

	localparam logic [2:0] STS_OK     = 3'd0;
	localparam logic [2:0] STS_SID    = 3'd1;
	localparam logic [2:0] STS_BIG    = 3'd2;
	localparam logic [2:0] STS_NOSND  = 3'd3;
	localparam logic [2:0] STS_WRONG  = 3'd4;
	localparam logic [2:0] STS_GONE   = 3'd5;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_EXEC   = 3'd1;
	localparam logic [2:0] PH_POPE   = 3'd2;
	localparam logic [2:0] PH_DQ     = 3'd3;
	localparam logic [2:0] PH_DQE    = 3'd4;
	localparam logic [2:0] PH_SCAN   = 3'd5;
	localparam logic [2:0] PH_FINAL  = 3'd6;
	localparam logic [2:0] PH_SECOND = 3'd7;

	typedef struct packed {
		logic [3:0]  target;
		logic        set_return;
		logic [2:0]  status;
		logic [3:0]  sender_id;
		logic        wake;
		logic [15:0] copy_len;
		logic [3:0]  copy_source;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       fire;
		logic       load;
	} ctl_cmd_t;

	typedef struct packed {
		logic emit;
		logic has2;
		logic want_pop;
		logic want_walk;
		logic q_nonempty;
		logic scan_last;
		logic out_free;
	} dp_sts_t;

	function automatic res_t mk_res(input logic [3:0] tgt, input logic setr,
			input logic [2:0] st, input logic [3:0] sid, input logic wk,
			input logic [15:0] clen, input logic [3:0] csrc, input logic lst);
		res_t r;
		r.target      = tgt;
		r.set_return  = setr;
		r.status      = st;
		r.sender_id   = sid;
		r.wake        = wk;
		r.copy_len    = clen;
		r.copy_source = csrc;
		r.last        = lst;
		return r;
	endfunction

endpackage

[rtl/core/srr_req_if.sv]
interface srr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  actor;
	logic [3:0]  peer;
	logic [15:0] msg_len;
	logic [15:0] buf_len;

	modport source (output valid, cmd, actor, peer, msg_len, buf_len, input ready);
	modport sink (input valid, cmd, actor, peer, msg_len, buf_len, output ready);
endinterface

[rtl/core/srr_rsp_if.sv]
interface srr_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  target;
	logic        set_return;
	logic [2:0]  status;
	logic [3:0]  sender_id;
	logic        wake;
	logic [15:0] copy_len;
	logic [3:0]  copy_source;
	logic        last;

	modport source (output valid, target, set_return, status, sender_id, wake, copy_len,
		copy_source, last, input ready);
	modport sink (input valid, target, set_return, status, sender_id, wake, copy_len,
		copy_source, last, output ready);
endinterface

[rtl/core/send_receive_reply_rendezvous.sv]
// Send/receive/reply rendezvous engine for up to PROCS processes. One command is
// taken at a time; results leave one beat each through an output register.
// Send, create, a receive with an empty queue, a refused command and a reply that
// finds no sender or the wrong replier give one result; an unknown command gives
// no result. A reply that reaches its sender and a send to a blocked receiver give
// two. A receive that pops its queue goes through the registered read of the sender
// queue RAM. Destroy walks the queue of waiting senders and then scans the reply
// table, one entry per cycle, before its final result. A stalled result port holds
// the walk.
module send_receive_reply_rendezvous
	import srr_pkg::*;
#(
	parameter int PROCS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	srr_req_if.sink    req,
	srr_rsp_if.source  rsp
);
	ctl_cmd_t ctl;
	dp_sts_t  sts;
	res_t     out_res;

	srr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	srr_dp #(.PROCS(PROCS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (req.cmd),
		.actor     (req.actor),
		.peer      (req.peer),
		.msg_len   (req.msg_len),
		.buf_len   (req.buf_len),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_res   (out_res)
	);

	assign rsp.target      = out_res.target;
	assign rsp.set_return  = out_res.set_return;
	assign rsp.status      = out_res.status;
	assign rsp.sender_id   = out_res.sender_id;
	assign rsp.wake        = out_res.wake;
	assign rsp.copy_len    = out_res.copy_len;
	assign rsp.copy_source = out_res.copy_source;
	assign rsp.last        = out_res.last;
endmodule

[rtl/core/srr_ram.sv]
module srr_ram #(
	parameter int W = 20,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/srr_ctrl.sv]
module srr_ctrl
	import srr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t ctl
);
	logic [2:0] ph_q;
	logic [2:0] ph_nx;
	logic       fire;

	assign req_ready = (ph_q == PH_IDLE);
	assign fire      = (ph_q != PH_IDLE) && (!sts.emit || sts.out_free);
	assign ctl.phase = ph_q;
	assign ctl.fire  = fire;
	assign ctl.load  = req_valid && req_ready;

	always_comb begin
		ph_nx = ph_q;
		unique case (ph_q)
			PH_IDLE: begin
				if (req_valid) ph_nx = PH_EXEC;
			end
			PH_EXEC: begin
				if (fire) begin
					if (sts.want_pop) ph_nx = PH_POPE;
					else if (sts.want_walk) ph_nx = PH_DQ;
					else if (sts.has2) ph_nx = PH_SECOND;
					else ph_nx = PH_IDLE;
				end
			end
			PH_POPE: begin
				if (fire) ph_nx = sts.has2 ? PH_SECOND : PH_IDLE;
			end
			PH_DQ: begin
				if (fire) ph_nx = sts.q_nonempty ? PH_DQE : PH_SCAN;
			end
			PH_DQE: begin
				if (fire) ph_nx = PH_DQ;
			end
			PH_SCAN: begin
				if (fire && sts.scan_last) ph_nx = PH_FINAL;
			end
			PH_FINAL, PH_SECOND: begin
				if (fire) ph_nx = PH_IDLE;
			end
			default: ph_nx = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			ph_q <= ph_nx;
		end
	end
endmodule

[rtl/core/srr_dp.sv]
module srr_dp
	import srr_pkg::*;
#(
	parameter int PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    ctl,
	output dp_sts_t     sts,
	input  logic [2:0]  cmd,
	input  logic [3:0]  actor,
	input  logic [3:0]  peer,
	input  logic [15:0] msg_len,
	input  logic [15:0] buf_len,
	input  logic        out_ready,
	output logic        out_valid,
	output res_t        out_res
);
	localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int CW = $clog2(PROCS + 1);
	localparam int QD = PROCS * PROCS;
	localparam int AW = $clog2(QD);

	logic [2:0]  c_q;
	logic [3:0]  a_q, p_q;
	logic [15:0] ml_q, bl_q;
	logic [3:0]  n_q;
	logic [PW-1:0] i_q;

	logic [1:0]    st_q    [PROCS];
	logic          alive_q [PROCS];
	logic [PW-1:0] head_q  [PROCS];
	logic [PW-1:0] tail_q  [PROCS];
	logic [CW-1:0] cnt_q   [PROCS];
	logic [3:0]    rfrom_q [PROCS];
	logic [15:0]   rblen_q [PROCS];
	logic [15:0]   rcvlen_q[PROCS];

	res_t res, res2, res2_q, out_q;
	logic ovalid_q;
	logic emit, has2, want_pop, want_walk, hit;

	logic [PW-1:0] ai, pi, si;
	logic a_in, p_in, s_in, live_a, live_p, live_s, s_ok;
	logic [3:0]  s;
	logic [15:0] len;
	logic [19:0] rdata;
	logic we, re;
	logic [AW-1:0] waddr, raddr;
	logic big_snd, big_rcv, big_rpl, q_full, a_nonempty;

	assign ai = PW'(a_q);
	assign pi = PW'(p_q);
	assign s  = rdata[19:16];
	assign len = rdata[15:0];
	assign si = PW'(s);
	assign a_in = int'(a_q) < PROCS;
	assign p_in = int'(p_q) < PROCS;
	assign s_in = int'(s) < PROCS;
	assign live_a = a_in && alive_q[ai];
	assign live_p = p_in && alive_q[pi];
	assign live_s = s_in && alive_q[si];
	assign s_ok = live_s && (st_q[si] == IPC_BSEND);
	assign big_snd = ml_q > rcvlen_q[pi];
	assign big_rcv = len > bl_q;
	assign big_rpl = ml_q > rblen_q[pi];
	assign q_full = cnt_q[pi] >= CW'(PROCS);
	assign a_nonempty = cnt_q[ai] != '0;

	always_comb begin
		res = '0;
		res2 = '0;
		emit = 1'b0;
		has2 = 1'b0;
		want_pop = 1'b0;
		want_walk = 1'b0;
		hit = 1'b0;
		unique case (ctl.phase)
			PH_EXEC: begin
				if (c_q == CMD_CREATE) begin
					emit = 1'b1;
					res = a_in ? mk_res(a_q, 1'b0, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1)
						: mk_res(a_q, 1'b1, STS_GONE, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
				end else if (c_q > CMD_CREATE) begin
					emit = 1'b0;
				end else if (!live_a) begin
					emit = 1'b1;
					res = mk_res(a_q, 1'b1, STS_GONE, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
				end else begin
					case (c_q)
						CMD_SEND: begin
							emit = 1'b1;
							if (!live_p) begin
								res = mk_res(a_q, 1'b1, STS_GONE, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
							end else if (st_q[pi] == IPC_BRECV) begin
								has2 = 1'b1;
								if (big_snd) begin
									res = mk_res(p_q, 1'b1, STS_BIG, 4'd0, 1'b1, 16'd0, 4'd0, 1'b0);
									res2 = mk_res(a_q, 1'b1, STS_BIG, 4'd0, 1'b0, 16'd0, 4'd0,
										1'b1);
								end else begin
									res = mk_res(p_q, 1'b1, STS_SID, a_q, 1'b1, ml_q,
										(ml_q != 16'd0) ? a_q : 4'd0, 1'b0);
									res2 = mk_res(a_q, 1'b1, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0,
										1'b1);
								end
							end else if (q_full) begin
								res = mk_res(a_q, 1'b1, STS_BIG, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
							end else begin
								res = mk_res(a_q, 1'b1, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
							end
						end
						CMD_RECV: begin
							if (a_nonempty) begin
								want_pop = 1'b1;
							end else begin
								emit = 1'b1;
								res = mk_res(a_q, 1'b1, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
							end
						end
						CMD_REPLY: begin
							emit = 1'b1;
							if (!live_p || st_q[pi] != IPC_BREPLY) begin
								res = mk_res(a_q, 1'b1, STS_NOSND, 4'd0, 1'b0, 16'd0, 4'd0,
									1'b1);
							end else if (rfrom_q[pi] != a_q) begin
								res = mk_res(a_q, 1'b1, STS_WRONG, 4'd0, 1'b0, 16'd0, 4'd0,
									1'b1);
							end else begin
								has2 = 1'b1;
								if (big_rpl) begin
									res = mk_res(p_q, 1'b1, STS_BIG, 4'd0, 1'b1, 16'd0, 4'd0, 1'b0);
									res2 = mk_res(a_q, 1'b1, STS_BIG, 4'd0, 1'b0, 16'd0, 4'd0,
										1'b1);
								end else begin
									res = mk_res(p_q, 1'b0, STS_OK, 4'd0, 1'b1, ml_q,
										(ml_q != 16'd0) ? a_q : 4'd0, 1'b0);
									res2 = mk_res(a_q, 1'b1, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0,
										1'b1);
								end
							end
						end
						default: want_walk = 1'b1;
					endcase
				end
			end
			PH_POPE: begin
				emit = 1'b1;
				if (!s_ok) begin
					res = mk_res(a_q, 1'b1, STS_NOSND, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
				end else if (big_rcv) begin
					has2 = 1'b1;
					res = mk_res(s, 1'b1, STS_BIG, 4'd0, 1'b1, 16'd0, 4'd0, 1'b0);
					res2 = mk_res(a_q, 1'b1, STS_BIG, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
				end else begin
					res = mk_res(a_q, 1'b1, STS_SID, s, 1'b0, len,
						(len != 16'd0) ? s : 4'd0, 1'b1);
				end
			end
			PH_DQE: begin
				hit = s_ok && (n_q != 4'd15);
				emit = hit;
				res = mk_res(s, 1'b1, STS_OK, 4'd0, 1'b1, 16'd0, 4'd0, 1'b0);
			end
			PH_SCAN: begin
				hit = alive_q[i_q] && (st_q[i_q] == IPC_BREPLY) && (rfrom_q[i_q] == a_q)
					&& (n_q != 4'd15);
				emit = hit;
				res = mk_res(4'(i_q), 1'b1, STS_OK, 4'd0, 1'b1, 16'd0, 4'd0, 1'b0);
			end
			PH_FINAL: begin
				emit = 1'b1;
				res = mk_res(a_q, 1'b0, STS_OK, 4'd0, 1'b0, 16'd0, 4'd0, 1'b1);
			end
			PH_SECOND: begin
				emit = 1'b1;
				res = res2_q;
			end
			default: emit = 1'b0;
		endcase
	end

	assign sts.emit = emit;
	assign sts.has2 = has2;
	assign sts.want_pop = want_pop;
	assign sts.want_walk = want_walk;
	assign sts.q_nonempty = a_nonempty;
	assign sts.scan_last = (i_q == PW'(PROCS - 1));
	assign sts.out_free = !ovalid_q || out_ready;

	assign we = ctl.fire && (ctl.phase == PH_EXEC) && (c_q == CMD_SEND) && live_a && live_p
		&& (st_q[pi] != IPC_BRECV) && !q_full;
	assign re = ctl.fire && (((ctl.phase == PH_EXEC) && (c_q == CMD_RECV) && live_a)
		|| (ctl.phase == PH_DQ)) && a_nonempty;
	assign waddr = AW'(pi) * AW'(PROCS) + AW'(tail_q[pi]);
	assign raddr = AW'(ai) * AW'(PROCS) + AW'(head_q[ai]);

	srr_ram #(.W(20), .D(QD)) u_queue (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({a_q, ml_q}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
		return (v == PW'(PROCS - 1)) ? '0 : v + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			c_q  <= cmd;
			a_q  <= actor;
			p_q  <= peer;
			ml_q <= msg_len;
			bl_q <= buf_len;
		end
		if (ctl.fire && emit) begin
			out_q <= res;
			if (has2) res2_q <= res2;
		end
		if (ctl.fire && ctl.phase == PH_EXEC && live_a && c_q != CMD_CREATE) begin
			if (c_q == CMD_SEND && live_p && (st_q[pi] == IPC_BRECV || !q_full)) begin
				rfrom_q[ai] <= p_q;
				rblen_q[ai] <= bl_q;
			end
			if (c_q == CMD_RECV) rcvlen_q[ai] <= bl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PROCS; k++) begin
				st_q[k]    <= IPC_RUN;
				alive_q[k] <= 1'b1;
				head_q[k]  <= '0;
				tail_q[k]  <= '0;
				cnt_q[k]   <= '0;
			end
			n_q      <= '0;
			i_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ctl.fire && emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (ctl.load) n_q <= '0;
			if (re) begin
				head_q[ai] <= wrap_inc(head_q[ai]);
				cnt_q[ai]  <= cnt_q[ai] - CW'(1);
			end
			if (we) begin
				tail_q[pi] <= wrap_inc(tail_q[pi]);
				cnt_q[pi]  <= cnt_q[pi] + CW'(1);
			end
			if (ctl.fire) begin
				case (ctl.phase)
					PH_EXEC: begin
						if (c_q == CMD_CREATE && a_in) begin
							alive_q[ai] <= 1'b1;
							st_q[ai]    <= IPC_RUN;
							head_q[ai]  <= '0;
							tail_q[ai]  <= '0;
							cnt_q[ai]   <= '0;
						end else if (live_a) begin
							case (c_q)
								CMD_SEND: begin
									if (live_p && st_q[pi] == IPC_BRECV) begin
										st_q[pi] <= IPC_RUN;
										if (!big_snd) st_q[ai] <= IPC_BREPLY;
									end else if (we) begin
										st_q[ai] <= IPC_BSEND;
									end
								end
								CMD_RECV: begin
									if (!a_nonempty) st_q[ai] <= IPC_BRECV;
								end
								CMD_REPLY: begin
									if (live_p && st_q[pi] == IPC_BREPLY && rfrom_q[pi] == a_q)
										st_q[pi] <= IPC_RUN;
								end
								CMD_DESTROY: begin
									alive_q[ai] <= 1'b0;
									st_q[ai]    <= IPC_RUN;
								end
								default: ;
							endcase
						end
					end
					PH_POPE: begin
						if (s_ok) st_q[si] <= big_rcv ? IPC_RUN : IPC_BREPLY;
					end
					PH_DQ: begin
						if (!a_nonempty) begin
							head_q[ai] <= '0;
							tail_q[ai] <= '0;
							i_q        <= '0;
						end
					end
					PH_DQE: begin
						if (hit) begin
							st_q[si] <= IPC_RUN;
							n_q      <= n_q + 4'd1;
						end
					end
					PH_SCAN: begin
						if (hit) begin
							st_q[i_q] <= IPC_RUN;
							n_q       <= n_q + 4'd1;
						end
						i_q <= i_q + PW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_res   = out_q;
endmodule

[verif/srr_tb_if.sv]
`timescale 1ns / 100ps
// interfaces come from the rtl; this file holds the shared call beat type for the bench
package srr_tb_pkg;
	import srr_pkg::*;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  actor;
		logic [3:0]  peer;
		logic [15:0] msg_len;
		logic [15:0] buf_len;
	} call_t;
endpackage

[verif/srr_checker.sv]
`timescale 1ns / 100ps
module srr_checker
	import srr_pkg::*;
	import srr_tb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srr_req_if.sink    req_mon,
	srr_rsp_if.sink    rsp_mon,
	output int         fail_count,
	output int         pending,
	output int         results_seen
);
	localparam int N = 16;

	logic [1:0]  ipc [N];
	logic        alive [N];
	logic [3:0]  q_snd [N][N];
	logic [15:0] q_len [N][N];
	logic [3:0]  q_head [N];
	logic [3:0]  q_tail [N];
	logic [4:0]  q_cnt [N];
	logic [15:0] rbuf [N];
	logic [3:0]  rfrom [N];
	logic [15:0] rplen [N];

	res_t expected_results[$];

	assign pending = expected_results.size();

	function automatic res_t r(input logic [3:0] tgt, input logic setr, input logic [2:0] st,
			input logic [3:0] sid, input logic wk, input logic [15:0] clen,
			input logic [3:0] csrc, input logic lst);
		res_t x;
		x = {tgt, setr, st, sid, wk, clen, csrc, lst};
		return x;
	endfunction

	function automatic bit is_live(input logic [3:0] p);
		return alive[p];
	endfunction

	task automatic predict_call(input call_t c);
		logic [3:0]  a, p, h, s;
		logic [15:0] len;
		int n;
		a = c.actor;
		p = c.peer;
		n = 0;
		if (c.cmd > CMD_CREATE)
			return;
		if (c.cmd == CMD_CREATE) begin
			alive[a] = 1;
			ipc[a] = IPC_RUN;
			q_head[a] = 0; q_tail[a] = 0; q_cnt[a] = 0;
			expected_results.push_back(r(a, 0, STS_OK, 0, 0, 0, 0, 1));
			return;
		end
		if (!is_live(a)) begin
			expected_results.push_back(r(a, 1, STS_GONE, 0, 0, 0, 0, 1));
			return;
		end
		case (c.cmd)
			CMD_SEND: begin
				if (!is_live(p)) begin
					expected_results.push_back(r(a, 1, STS_GONE, 0, 0, 0, 0, 1));
				end else if (ipc[p] == IPC_BRECV) begin
					rfrom[a] = p;
					rplen[a] = c.buf_len;
					ipc[p] = IPC_RUN;
					if (c.msg_len > rbuf[p]) begin
						expected_results.push_back(r(p, 1, STS_BIG, 0, 1, 0, 0, 0));
						expected_results.push_back(r(a, 1, STS_BIG, 0, 0, 0, 0, 1));
					end else begin
						ipc[a] = IPC_BREPLY;
						expected_results.push_back(r(p, 1, STS_SID, a, 1, c.msg_len,
							c.msg_len != 0 ? a : 4'd0, 0));
						expected_results.push_back(r(a, 1, STS_OK, 0, 0, 0, 0, 1));
					end
				end else if (q_cnt[p] >= N) begin
					expected_results.push_back(r(a, 1, STS_BIG, 0, 0, 0, 0, 1));
				end else begin
					rfrom[a] = p;
					rplen[a] = c.buf_len;
					q_snd[p][q_tail[p]] = a;
					q_len[p][q_tail[p]] = c.msg_len;
					q_tail[p] = q_tail[p] + 1;
					q_cnt[p] = q_cnt[p] + 1;
					ipc[a] = IPC_BSEND;
					expected_results.push_back(r(a, 1, STS_OK, 0, 0, 0, 0, 1));
				end
			end
			CMD_RECV: begin
				rbuf[a] = c.buf_len;
				if (q_cnt[a] > 0) begin
					h = q_head[a];
					s = q_snd[a][h];
					len = q_len[a][h];
					q_head[a] = h + 1;
					q_cnt[a] = q_cnt[a] - 1;
					if (!is_live(s) || ipc[s] != IPC_BSEND) begin
						expected_results.push_back(r(a, 1, STS_NOSND, 0, 0, 0, 0, 1));
					end else if (len > c.buf_len) begin
						ipc[s] = IPC_RUN;
						expected_results.push_back(r(s, 1, STS_BIG, 0, 1, 0, 0, 0));
						expected_results.push_back(r(a, 1, STS_BIG, 0, 0, 0, 0, 1));
					end else begin
						ipc[s] = IPC_BREPLY;
						expected_results.push_back(r(a, 1, STS_SID, s, 0, len,
							len != 0 ? s : 4'd0, 1));
					end
				end else begin
					ipc[a] = IPC_BRECV;
					expected_results.push_back(r(a, 1, STS_OK, 0, 0, 0, 0, 1));
				end
			end
			CMD_REPLY: begin
				if (!is_live(p) || ipc[p] != IPC_BREPLY) begin
					expected_results.push_back(r(a, 1, STS_NOSND, 0, 0, 0, 0, 1));
				end else if (rfrom[p] != a) begin
					expected_results.push_back(r(a, 1, STS_WRONG, 0, 0, 0, 0, 1));
				end else begin
					ipc[p] = IPC_RUN;
					if (c.msg_len > rplen[p]) begin
						expected_results.push_back(r(p, 1, STS_BIG, 0, 1, 0, 0, 0));
						expected_results.push_back(r(a, 1, STS_BIG, 0, 0, 0, 0, 1));
					end else begin
						expected_results.push_back(r(p, 0, STS_OK, 0, 1, c.msg_len,
							c.msg_len != 0 ? a : 4'd0, 0));
						expected_results.push_back(r(a, 1, STS_OK, 0, 0, 0, 0, 1));
					end
				end
			end
			default: begin
				alive[a] = 0;
				ipc[a] = IPC_RUN;
				while (q_cnt[a] > 0) begin
					h = q_head[a];
					s = q_snd[a][h];
					q_head[a] = h + 1;
					q_cnt[a] = q_cnt[a] - 1;
					if (is_live(s) && ipc[s] == IPC_BSEND && n < 15) begin
						ipc[s] = IPC_RUN;
						expected_results.push_back(r(s, 1, STS_OK, 0, 1, 0, 0, 0));
						n++;
					end
				end
				q_head[a] = 0; q_tail[a] = 0; q_cnt[a] = 0;
				for (int i = 0; i < N; i++) begin
					if (alive[i] && ipc[i] == IPC_BREPLY && rfrom[i] == a && n < 15) begin
						ipc[i] = IPC_RUN;
						expected_results.push_back(r(i, 1, STS_OK, 0, 1, 0, 0, 0));
						n++;
					end
				end
				expected_results.push_back(r(a, 0, STS_OK, 0, 0, 0, 0, 1));
			end
		endcase
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		call_t c;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
			expected_results.delete();
			for (int i = 0; i < N; i++) begin
				ipc[i] = IPC_RUN;
				alive[i] = 1;
				q_head[i] = 0; q_tail[i] = 0; q_cnt[i] = 0;
				rbuf[i] = 0; rfrom[i] = 0; rplen[i] = 0;
			end
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result beat for target %0d with nothing expected", rsp_mon.target);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("target", e.target, rsp_mon.target);
					check_field("set_return", e.set_return, rsp_mon.set_return);
					check_field("status", e.status, rsp_mon.status);
					check_field("sender_id", e.sender_id, rsp_mon.sender_id);
					check_field("wake", e.wake, rsp_mon.wake);
					check_field("copy_len", e.copy_len, rsp_mon.copy_len);
					check_field("copy_source", e.copy_source, rsp_mon.copy_source);
					check_field("last", e.last, rsp_mon.last);
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				c = {req_mon.cmd, req_mon.actor, req_mon.peer, req_mon.msg_len,
					req_mon.buf_len};
				predict_call(c);
			end
		end
	end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import srr_pkg::*;
	import srr_tb_pkg::*;

	logic clk;
	logic arst_n;
	int   cycle;
	int   fail_count, pending, results_seen;
	int   send_idle_pct, recv_stall_pct;
	int   hold_off;
	int   calls_sent;

	srr_req_if req ();
	srr_rsp_if rsp ();

	send_receive_reply_rendezvous #(.PROCS(16)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	srr_checker chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver side: random stall, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic offer(input call_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		{req.cmd, req.actor, req.peer, req.msg_len, req.buf_len} <= c;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		calls_sent++;
	endtask

	task automatic go_quiet();
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic call_t mk(input logic [2:0] c, input logic [3:0] a,
			input logic [3:0] p, input logic [15:0] m, input logic [15:0] b);
		return {c, a, p, m, b};
	endfunction

	function automatic logic [15:0] rlen();
		case ($urandom_range(3))
			0: return 16'(0);
			1: return 16'hffff;
			2: return 16'($urandom_range(64));
			default: return 16'($urandom);
		endcase
	endfunction

	// random mix: mostly send/receive/reply rounds among a few processes
	task automatic random_calls(input int count);
		call_t c;
		logic [3:0] a, p;
		for (int k = 0; k < count; k++) begin
			a = 4'($urandom_range($urandom_range(1) ? 5 : 15));
			p = 4'($urandom_range($urandom_range(1) ? 5 : 15));
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5: c = mk(CMD_SEND, a, p, rlen(), rlen());
				6, 7, 8, 9, 10: c = mk(CMD_RECV, a, p, rlen(), rlen());
				11, 12, 13, 14, 15: c = mk(CMD_REPLY, a, p, rlen(), rlen());
				16: c = mk(CMD_DESTROY, a, p, rlen(), rlen());
				17, 18: c = mk(CMD_CREATE, a, p, rlen(), rlen());
				default: c = {3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom),
					16'($urandom), 16'($urandom)};
			endcase
			offer(c);
		end
	endtask

	initial begin
		cycle = 0;
		hold_off = 0;
		calls_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		req.valid = 0;
		{req.cmd, req.actor, req.peer, req.msg_len, req.buf_len} = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		offer(mk(CMD_RECV, 1, 0, 0, 16'd100));
		offer(mk(CMD_SEND, 2, 1, 16'd100, 16'hffff));
		offer(mk(CMD_REPLY, 3, 2, 0, 0));
		offer(mk(CMD_REPLY, 1, 2, 16'hffff, 0));
		offer(mk(CMD_RECV, 1, 0, 0, 16'd10));
		offer(mk(CMD_SEND, 2, 1, 16'd11, 0));
		offer(mk(CMD_SEND, 3, 4, 16'hffff, 16'hffff));
		offer(mk(CMD_SEND, 5, 4, 0, 16'd8));
		offer(mk(CMD_RECV, 4, 0, 0, 16'd5));
		offer(mk(CMD_RECV, 4, 0, 0, 16'hffff));
		offer(mk(CMD_REPLY, 4, 5, 16'd8, 0));
		offer(mk(CMD_SEND, 6, 7, 0, 0));
		offer(mk(CMD_DESTROY, 6, 0, 0, 0));
		offer(mk(CMD_RECV, 7, 0, 0, 0));
		offer(mk(CMD_SEND, 8, 6, 0, 0));
		offer(mk(CMD_SEND, 6, 8, 0, 0));
		offer(mk(CMD_CREATE, 6, 0, 0, 0));
		offer(mk(CMD_SEND, 9, 10, 0, 0));
		offer(mk(CMD_RECV, 10, 0, 0, 0));
		offer(mk(CMD_DESTROY, 10, 0, 0, 0));
		offer(mk(CMD_CREATE, 10, 0, 0, 0));
		offer(mk(CMD_CREATE, 15, 15, 0, 0));
		offer(mk(3'd7, 4'hf, 4'hf, 16'hffff, 16'hffff));
		go_quiet();

		// fill one queue to full, then overflow and destroy it
		for (int i = 0; i < 16; i++) offer(mk(CMD_SEND, 4'(i), 4'd0, 16'(i), 0));
		offer(mk(CMD_SEND, 1, 0, 0, 0));
		offer(mk(CMD_DESTROY, 0, 0, 0, 0));
		offer(mk(CMD_CREATE, 0, 0, 0, 0));
		for (int i = 0; i < 16; i++) offer(mk(CMD_CREATE, 4'(i), 0, 0, 0));
		go_quiet();

		random_calls(40);
		send_idle_pct = 76;
		random_calls(40);
		send_idle_pct = 0;
		recv_stall_pct = 76;
		random_calls(40);
		send_idle_pct = 21;
		recv_stall_pct = 21;
		random_calls(40);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off <= 300;
		random_calls(30);
		go_quiet();
		random_calls(30);
		go_quiet();

		$display("%0d commands accepted, %0d result beats checked across idle and stall phases",
			calls_sent, results_seen);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
